@@ rtl/sacrr_pkg.sv @@
package sacrr_pkg;

    localparam int ADDR_W      = 32;
    localparam int CNT_W       = 32;
    localparam int WAY_OUT_W   = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 4;
    localparam int FIELD_W     = 4;
    // index_bits is a 4-bit field, so the raw set index is at most 15 bits wide
    localparam int RAW_SET_W   = 15;
    localparam int TAG_SHIFT_W = 5;

    localparam logic [FIELD_W-1:0] RESET_OFFSET_BITS = 4'd5;
    localparam logic [FIELD_W-1:0] RESET_INDEX_BITS  = 4'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET_BITS = 2'd0,
        CFG_INDEX_BITS  = 2'd1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REDUCE,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic reduce_step;
        logic rd_en;
        logic commit;
    } t_ctrl_cmd;

    typedef struct packed {
        logic clr_last;
        logic set_ready;
    } t_dp_status;

endpackage

@@ rtl/sacrr_if.sv @@
interface sacrr_req_if;
    import sacrr_pkg::*;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] address;
    modport source(output valid, output address, input ready);
    modport sink(input valid, input address, output ready);
endinterface

interface sacrr_rsp_if;
    import sacrr_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic [WAY_OUT_W-1:0] way;
    logic [CNT_W-1:0]     hit_count;
    logic [CNT_W-1:0]     miss_count;
    modport source(output valid, output hit, output way, output hit_count,
                   output miss_count, input ready);
    modport sink(input valid, input hit, input way, input hit_count,
                 input miss_count, output ready);
endinterface

interface sacrr_cfg_if;
    import sacrr_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

@@ rtl/set_assoc_cache_round_robin.sv @@
// Sequence: an accepted request has its set index reduced (3 steps of the reciprocal
//   set-index reduction when NUM_SETS is not a power of two), then the memories are read
//   and the response is registered at commit. One request at a time: the metadata/tag
//   memory read and the write-back of a fill come before the next lookup.
// Reset: synchronous, active low; a clear sweep over all NUM_SETS sets then zeroes all valid
//   bits and round-robin pointers, with no request taken meanwhile (config writes still are).
module set_assoc_cache_round_robin #(
    parameter int WAYS     = 4,
    parameter int NUM_SETS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sacrr_req_if.sink   i_req,
    sacrr_rsp_if.source o_rsp,
    sacrr_cfg_if.sink   i_cfg
);
    import sacrr_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status status;

    // Configuration writes are always taken; the split applies from the next lookup on.
    assign i_cfg.ready = 1'b1;

    // Sequencer: clear sweep, request accept, set-index reduction, memory read, then
    // compare and fill. The response sits in an output register, so a new request is
    // accepted while the previous response still waits for the sink.
    sacrr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Datapath: address split, tag and metadata memories (one row per set), parallel tag
    // compare across the ways, round-robin fill, saturating hit and miss totals.
    sacrr_dp #(
        .WAYS     (WAYS),
        .NUM_SETS (NUM_SETS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_req_address (i_req.address),
        .i_cfg_we      (i_cfg.valid),
        .i_cfg_index   (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .o_rsp_hit     (o_rsp.hit),
        .o_rsp_way     (o_rsp.way),
        .o_hit_count   (o_rsp.hit_count),
        .o_miss_count  (o_rsp.miss_count)
    );

endmodule

@@ rtl/sacrr_ctrl.sv @@
module sacrr_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    output logic                  o_req_ready,
    output logic                  o_rsp_valid,
    input  logic                  i_rsp_ready,
    input  sacrr_pkg::t_dp_status i_status,
    output sacrr_pkg::t_ctrl_cmd  o_cmd
);
    import sacrr_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_rsp_valid;
    logic   n_rsp_valid;
    logic   rsp_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    assign rsp_free = !r_rsp_valid || i_rsp_ready;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        n_rsp_valid = r_rsp_valid && !i_rsp_ready;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                if (i_status.set_ready) begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = ST_UPDATE;
                end else begin
                    o_cmd.reduce_step = 1'b1;
                end
            end
            ST_UPDATE: begin
                // hold the lookup until the response slot is free
                if (rsp_free) begin
                    o_cmd.commit = 1'b1;
                    n_rsp_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    assign o_rsp_valid = r_rsp_valid;

endmodule

@@ rtl/sacrr_dp.sv @@
module sacrr_dp #(
    parameter int WAYS     = 4,
    parameter int NUM_SETS = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  sacrr_pkg::t_ctrl_cmd             i_cmd,
    output sacrr_pkg::t_dp_status            o_status,
    input  logic [sacrr_pkg::ADDR_W-1:0]     i_req_address,
    input  logic                             i_cfg_we,
    input  logic [sacrr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sacrr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                             o_rsp_hit,
    output logic [sacrr_pkg::WAY_OUT_W-1:0]  o_rsp_way,
    output logic [sacrr_pkg::CNT_W-1:0]      o_hit_count,
    output logic [sacrr_pkg::CNT_W-1:0]      o_miss_count
);
    import sacrr_pkg::*;

    localparam int  SETW   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int  PTRW   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int  MW     = PTRW + WAYS;
    localparam int  RAWX_W = (SETW > RAW_SET_W) ? SETW : RAW_SET_W;
    localparam bit  POW2   = (NUM_SETS & (NUM_SETS - 1)) == 0;

    typedef logic [WAYS-1:0][ADDR_W-1:0] t_tag_row;

    // configuration
    logic [FIELD_W-1:0] r_offset_bits;
    logic [FIELD_W-1:0] r_index_bits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_bits <= RESET_OFFSET_BITS;
            r_index_bits  <= RESET_INDEX_BITS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_OFFSET_BITS: r_offset_bits <= i_cfg_data[FIELD_W-1:0];
                CFG_INDEX_BITS:  r_index_bits  <= i_cfg_data[FIELD_W-1:0];
                default:         ;
            endcase
        end
    end

    // address split
    logic [ADDR_W-1:0]    shifted;
    logic [RAW_SET_W-1:0] idx_mask;
    logic [RAW_SET_W-1:0] raw_set;
    logic [RAWX_W-1:0]    raw_ext;
    logic [TAG_SHIFT_W-1:0] tag_shift;
    logic [ADDR_W-1:0]    r_tag;

    assign shifted   = i_req_address >> r_offset_bits;
    assign idx_mask  = ~({RAW_SET_W{1'b1}} << r_index_bits);
    assign raw_set   = shifted[RAW_SET_W-1:0] & idx_mask;
    assign raw_ext   = RAWX_W'(raw_set);
    assign tag_shift = TAG_SHIFT_W'(r_offset_bits) + TAG_SHIFT_W'(r_index_bits);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tag <= i_req_address >> tag_shift;
        end
    end

    // set index reduction modulo NUM_SETS
    logic [SETW-1:0] set_idx;
    logic            set_ready;

    generate
        if (POW2) begin : g_pow2
            logic [SETW-1:0] r_set;
            always_ff @(posedge i_clk) begin
                if (i_cmd.load) begin
                    r_set <= raw_ext[SETW-1:0] & SETW'(NUM_SETS - 1);
                end
            end
            assign set_idx   = r_set;
            assign set_ready = 1'b1;
        end else begin : g_recip
            // reciprocal multiply: estimate the quotient (low by at most one),
            // subtract it back, then correct once; one register stage per step
            localparam int RECIP_SH = 16;
            localparam int RECIP_M  = (1 << RECIP_SH) / NUM_SETS;
            localparam logic [FIELD_W-1:0] STEPS = FIELD_W'(3);
            logic [RAW_SET_W-1:0] r_x;
            logic [RAW_SET_W-1:0] r_q;
            logic [RAW_SET_W-1:0] r_diff;
            logic [SETW-1:0]      r_rem;
            logic [FIELD_W-1:0]   r_cnt;
            logic [ADDR_W-1:0]    q_prod;
            logic [ADDR_W-1:0]    back_prod;

            assign q_prod    = ADDR_W'(r_x) * ADDR_W'(RECIP_M);
            assign back_prod = ADDR_W'(r_q) * ADDR_W'(NUM_SETS);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_cnt <= '0;
                end else if (i_cmd.load) begin
                    r_cnt <= STEPS;
                end else if (i_cmd.reduce_step) begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_cmd.load) begin
                    r_x <= raw_set;
                end else if (i_cmd.reduce_step) begin
                    r_q    <= RAW_SET_W'(q_prod >> RECIP_SH);
                    r_diff <= RAW_SET_W'(ADDR_W'(r_x) - back_prod);
                    if (ADDR_W'(r_diff) >= ADDR_W'(NUM_SETS)) begin
                        r_rem <= SETW'(ADDR_W'(r_diff) - ADDR_W'(NUM_SETS));
                    end else begin
                        r_rem <= SETW'(r_diff);
                    end
                end
            end

            assign set_idx   = r_rem;
            assign set_ready = (r_cnt == '0);
        end
    endgenerate

    // clear sweep of the metadata memory
    logic [SETW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    assign o_status.clr_last  = (r_clr_addr == SETW'(NUM_SETS - 1));
    assign o_status.set_ready = set_ready;

    // metadata memory: {pointer, valid bits} per set
    logic [MW-1:0]   r_meta_mem [NUM_SETS];
    logic [MW-1:0]   r_meta_q;
    t_tag_row        r_tag_mem [NUM_SETS];
    t_tag_row        r_tags_q;

    logic [WAYS-1:0] meta_valid;
    logic [PTRW-1:0] meta_ptr;
    logic            hit_found;
    logic [PTRW-1:0] hit_way;
    logic [PTRW-1:0] fill_way;
    logic [WAYS-1:0] fill_valid;
    t_tag_row        tag_wrow;
    logic            fill_we;
    logic            meta_we;
    logic [SETW-1:0] meta_waddr;
    logic [MW-1:0]   meta_wdata;

    assign meta_valid = r_meta_q[WAYS-1:0];
    assign meta_ptr   = r_meta_q[MW-1:WAYS];

    always_comb begin
        hit_found = 1'b0;
        hit_way   = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (!hit_found && meta_valid[w] && (r_tags_q[w] == r_tag)) begin
                hit_found = 1'b1;
                hit_way   = PTRW'(w);
            end
        end
        fill_way   = (meta_ptr == PTRW'(WAYS - 1)) ? '0 : meta_ptr + 1'b1;
        fill_valid = meta_valid | (WAYS'(1) << fill_way);
        tag_wrow   = r_tags_q;
        tag_wrow[fill_way] = r_tag;
    end

    assign fill_we    = i_cmd.commit && !hit_found;
    assign meta_we    = i_cmd.clr_step || fill_we;
    assign meta_waddr = i_cmd.clr_step ? r_clr_addr : set_idx;
    assign meta_wdata = i_cmd.clr_step ? '0 : {fill_way, fill_valid};

    always_ff @(posedge i_clk) begin
        if (meta_we) begin
            r_meta_mem[meta_waddr] <= meta_wdata;
        end
        if (i_cmd.rd_en) begin
            r_meta_q <= r_meta_mem[set_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (fill_we) begin
            r_tag_mem[set_idx] <= tag_wrow;
        end
        if (i_cmd.rd_en) begin
            r_tags_q <= r_tag_mem[set_idx];
        end
    end

    // totals and response payload
    logic [CNT_W-1:0]     r_hits;
    logic [CNT_W-1:0]     r_misses;
    logic                 r_rsp_hit;
    logic [WAY_OUT_W-1:0] r_rsp_way;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hits   <= '0;
            r_misses <= '0;
        end else if (i_cmd.commit) begin
            if (hit_found) begin
                if (r_hits != '1) begin
                    r_hits <= r_hits + 1'b1;
                end
            end else if (r_misses != '1) begin
                r_misses <= r_misses + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_rsp_hit <= hit_found;
            r_rsp_way <= hit_found ? WAY_OUT_W'(hit_way) : WAY_OUT_W'(fill_way);
        end
    end

    assign o_rsp_hit    = r_rsp_hit;
    assign o_rsp_way    = r_rsp_way;
    assign o_hit_count  = r_hits;
    assign o_miss_count = r_misses;

endmodule

@@ rtl/sacrr_checker.sv @@
module sacrr_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_req_valid,
    input logic                               i_req_ready,
    input logic                               i_rsp_valid,
    input logic                               i_rsp_ready,
    input logic                               i_rsp_hit,
    input logic [sacrr_pkg::WAY_OUT_W-1:0]    i_rsp_way,
    input logic [sacrr_pkg::CNT_W-1:0]        i_hit_count,
    input logic [sacrr_pkg::CNT_W-1:0]        i_miss_count
);
    import sacrr_pkg::*;

    // one request in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request accepted while a lookup is in flight");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_rsp_hit) && $stable(i_rsp_way)))
        else $error("stalled response changed");

    a_totals_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
            (i_hit_count >= $past(i_hit_count)) && (i_miss_count >= $past(i_miss_count)))
        else $error("hit or miss total decreased");

    a_total_counts_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_hit ? (i_hit_count != '0) : (i_miss_count != '0)))
        else $error("response not reflected in its total");

endmodule

bind set_assoc_cache_round_robin sacrr_checker u_sacrr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_hit    (o_rsp.hit),
    .i_rsp_way    (o_rsp.way),
    .i_hit_count  (o_rsp.hit_count),
    .i_miss_count (o_rsp.miss_count)
);
